// ----- hw/rtl/gain_fold_bitcrusher_defines.svh -----
// Assertion macros for the gain_fold_bitcrusher checker.
// Depends on nothing; expects clk and rst_n in the using scope.
`ifndef GAIN_FOLD_BITCRUSHER_DEFINES_SVH
`define GAIN_FOLD_BITCRUSHER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GFB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define GFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/gfb_pkg.sv -----
// Shared types and constants of the gain/fold bitcrusher.
// Depends on nothing.
package gfb_pkg;

    localparam int DEPTH_W = 4;
    localparam int GAIN_W  = 16;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int REG_W   = 2;

    localparam logic [REG_W-1:0] REG_BIT_DEPTH = 2'd0;
    localparam logic [REG_W-1:0] REG_GAIN      = 2'd1;
    localparam logic [REG_W-1:0] REG_FOLD_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CLIP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRAP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FOLD = 2'd2;

    localparam logic [DEPTH_W-1:0] BIT_DEPTH_RST = 4'd8;
    localparam logic [GAIN_W-1:0]  GAIN_RST      = 16'd16384;
    localparam logic [MODE_W-1:0]  FOLD_MODE_RST = MODE_CLIP;

    typedef struct packed {
        logic [DEPTH_W-1:0] bit_depth;
        logic [GAIN_W-1:0]  gain;
        logic [MODE_W-1:0]  fold_mode;
    } cfg_t;

endpackage

// ----- hw/rtl/gain_fold_bitcrusher.sv -----
// Gain, fold and bitcrush pipeline: multiply, limit, round, rescale.
// An accepted start passes the product, limit, quantizer and output registers to the done strobe with audio_out.
// Throughput: one sample per cycle; busy stays low, set by the 4-stage pipeline.
// Reset clears all valid bits and loads the register defaults (8 bits, unity, clip).
// Depends on gfb_pkg, gfb_regs, gfb_limit, gfb_quant.
module gain_fold_bitcrusher #(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gfb_pkg::ADDR_W-1:0]    paddr,
    input  logic [gfb_pkg::DATA_W-1:0]    pwdata,
    output logic [gfb_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] audio_in,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] audio_out
);
    import gfb_pkg::*;

    localparam int PW = SAMPLE_BITS + 17;
    localparam int VW = SAMPLE_BITS + 18;

    cfg_t                 cfg;
    logic                 accept;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    logic                 prod_vld_reg;
    logic                 lim_vld;
    logic signed [VW-1:0] lim;

    gfb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign prod_next = PW'(audio_in) * PW'($signed({1'b0, cfg.gain}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_vld_reg <= 1'b0;
        else
            prod_vld_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            prod_reg <= prod_next;
    end

    gfb_limit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_limit (
        .clk       (clk),
        .rst_n     (rst_n),
        .fold_mode (cfg.fold_mode),
        .in_vld    (prod_vld_reg),
        .prod      (prod_reg),
        .out_vld   (lim_vld),
        .lim       (lim)
    );

    gfb_quant #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_quant (
        .clk       (clk),
        .rst_n     (rst_n),
        .bit_depth (cfg.bit_depth),
        .in_vld    (lim_vld),
        .lim       (lim),
        .out_vld   (done),
        .sample    (audio_out)
    );

endmodule

// ----- hw/rtl/gfb_regs.sv -----
// APB configuration registers of the gain/fold bitcrusher.
// Depends on gfb_pkg.
module gfb_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gfb_pkg::ADDR_W-1:0] paddr,
    input  logic [gfb_pkg::DATA_W-1:0] pwdata,
    output logic [gfb_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output gfb_pkg::cfg_t              cfg
);
    import gfb_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             wr_en;
    logic [REG_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_BIT_DEPTH: cfg_next.bit_depth = pwdata[DEPTH_W-1:0];
                REG_GAIN:      cfg_next.gain      = pwdata[GAIN_W-1:0];
                REG_FOLD_MODE: cfg_next.fold_mode = pwdata[MODE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_BIT_DEPTH: prdata = DATA_W'(cfg_reg.bit_depth);
            REG_GAIN:      prdata = DATA_W'(cfg_reg.gain);
            REG_FOLD_MODE: prdata = DATA_W'(cfg_reg.fold_mode);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_depth <= BIT_DEPTH_RST;
            cfg_reg.gain      <= GAIN_RST;
            cfg_reg.fold_mode <= FOLD_MODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/gfb_limit.sv -----
// Limiter stage: clip, wrap once or fold once around full scale.
// Depends on gfb_pkg.
module gfb_limit #(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gfb_pkg::MODE_W-1:0]    fold_mode,
    input  logic                          in_vld,
    input  logic signed [SAMPLE_BITS+16:0] prod,
    output logic                          out_vld,
    output logic signed [SAMPLE_BITS+17:0] lim
);
    import gfb_pkg::*;

    localparam int VW = SAMPLE_BITS + 18;
    localparam logic signed [VW-1:0] ONE =
        {{(VW-SAMPLE_BITS-14){1'b0}}, 1'b1, {(SAMPLE_BITS+13){1'b0}}};
    localparam logic signed [VW-1:0] TWO = ONE <<< 1;

    logic signed [VW-1:0] p;
    logic signed [VW-1:0] lim_next;
    logic signed [VW-1:0] lim_reg;
    logic                 vld_reg;

    assign p = VW'(prod);

    always_comb
    begin
        lim_next = p;
        case (fold_mode)
            MODE_WRAP:
            begin
                if (p > ONE)
                    lim_next = p - ONE;
                else if (p < -ONE)
                    lim_next = p + ONE;
            end
            MODE_FOLD:
            begin
                if (p > ONE)
                    lim_next = TWO - p;
                else if (p < -ONE)
                    lim_next = -TWO - p;
            end
            default:
            begin
                if (p > ONE)
                    lim_next = ONE;
                else if (p < -ONE)
                    lim_next = -ONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
            lim_reg <= lim_next;
    end

    assign out_vld = vld_reg;
    assign lim     = lim_reg;

endmodule

// ----- hw/rtl/gfb_quant.sv -----
// Quantizer stages: round up to the bit-depth grid, rescale and saturate.
// Depends on gfb_pkg.
module gfb_quant #(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [gfb_pkg::DEPTH_W-1:0]    bit_depth,
    input  logic                           in_vld,
    input  logic signed [SAMPLE_BITS+17:0] lim,
    output logic                           out_vld,
    output logic signed [SAMPLE_BITS-1:0]  sample
);
    import gfb_pkg::*;

    localparam int VW = SAMPLE_BITS + 18;
    localparam int SW = $clog2(SAMPLE_BITS + 15);
    localparam int NMAX_I = (SAMPLE_BITS < 15) ? SAMPLE_BITS : 15;
    localparam logic [DEPTH_W-1:0] NMAX = DEPTH_W'(NMAX_I);
    localparam logic [DEPTH_W-1:0] NMIN = DEPTH_W'(2);
    localparam logic signed [VW-1:0] MAXV =
        {{(VW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [VW-1:0] MINV = ~MAXV;

    logic [DEPTH_W-1:0]   n;
    logic [SW-1:0]        rsh;
    logic [SW-1:0]        lsh_next;
    logic signed [VW-1:0] rnd;
    logic signed [VW-1:0] sum;
    logic signed [VW-1:0] k_next;
    logic signed [VW-1:0] k_reg;
    logic [SW-1:0]        lsh_reg;
    logic                 k_vld_reg;
    logic signed [VW-1:0] q;
    logic signed [SAMPLE_BITS-1:0] out_next;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic                 out_vld_reg;

    always_comb
    begin
        n = bit_depth;
        if (n < NMIN)
            n = NMIN;
        if (n > NMAX)
            n = NMAX;
    end

    assign rsh      = SW'(SAMPLE_BITS + 14) - SW'(n);
    assign lsh_next = SW'(SAMPLE_BITS) - SW'(n);
    assign rnd      = (VW'(1) <<< rsh) - VW'(1);
    assign sum      = lim + rnd;
    assign k_next   = sum >>> rsh;

    assign q = k_reg <<< lsh_reg;

    always_comb
    begin
        if (q > MAXV)
            out_next = MAXV[SAMPLE_BITS-1:0];
        else if (q < MINV)
            out_next = MINV[SAMPLE_BITS-1:0];
        else
            out_next = q[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            k_vld_reg   <= in_vld;
            out_vld_reg <= k_vld_reg;
            if (k_vld_reg)
                out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            k_reg   <= k_next;
            lsh_reg <= lsh_next;
        end
    end

    assign out_vld = out_vld_reg;
    assign sample  = out_reg;

endmodule

// ----- hw/rtl/gfb_checker.sv -----
// Port-level checker for gain_fold_bitcrusher, attached by bind.
// Depends on gain_fold_bitcrusher_defines.svh.
`include "gain_fold_bitcrusher_defines.svh"

module gfb_checker #(
    parameter int SAMPLE_BITS = 16
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic signed [SAMPLE_BITS-1:0] audio_out
);

`GFB_ASSERT_SAME(a_latency, start && !busy, ##4 done, "request not answered after 4 cycles")
`GFB_ASSERT_SAME(a_no_spurious, done, $past(start && !busy, 4), "result without request")
`GFB_ASSERT_SAME(a_out_hold, !done, $stable(audio_out), "audio_out changed without strobe")
`GFB_ASSERT_NEXT(a_one_each, !(start && !busy), ##3 !done, "extra result strobe")

endmodule

bind gain_fold_bitcrusher gfb_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_gfb_checker (.*);

// ----- bench/gain_fold_bitcrusher_tb.sv -----
// Self-checking bench for gain_fold_bitcrusher: gain, clip/wrap/fold and upward quantization.
// Directed table, then random phases under random configs, checked by a local predictor.
// Depends on gfb_pkg and the gain_fold_bitcrusher RTL.
module gain_fold_bitcrusher_tb;
    import gfb_pkg::*;

    localparam int SAMPLE_BITS     = 16;
    localparam int GAIN_FRAC       = 14;
    localparam int PROD_FRAC       = SAMPLE_BITS - 1 + GAIN_FRAC;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int MAX_GAP         = 16;
    localparam int STALL_LIMIT     = 1000;
    localparam int TAIL_CYCLES     = 8;
    localparam int REPORT_LIMIT    = 10;
    localparam int N_DIRECTED      = 25;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [DEPTH_W-1:0]            depth;
        logic [GAIN_W-1:0]             gn;
        logic [MODE_W-1:0]             mode;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          known;
        logic signed [SAMPLE_BITS-1:0] result;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ADDR_W-1:0]             paddr;
    logic [DATA_W-1:0]             pwdata;
    logic [DATA_W-1:0]             prdata;
    logic                          pready;
    logic                          start;
    logic                          busy;
    logic signed [SAMPLE_BITS-1:0] audio_in;
    logic                          done;
    logic signed [SAMPLE_BITS-1:0] audio_out;

    cfg_t                          cfg;
    logic signed [SAMPLE_BITS-1:0] crushed_due [$];
    logic signed [SAMPLE_BITS-1:0] due_head;
    int                            fault_count = 0;
    int                            stall_count = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{4'd8,  16'd16384, MODE_CLIP,   16'sd0,      1'b1, 16'sd0},
        '{4'd8,  16'd16384, MODE_CLIP,   16'sd32767,  1'b1, 16'sd32767},
        '{4'd8,  16'd16384, MODE_CLIP,   -16'sd32768, 1'b1, -16'sd32768},
        '{4'd8,  16'd16384, MODE_CLIP,   16'sd1,      1'b1, 16'sd256},
        '{4'd8,  16'd16384, MODE_CLIP,   -16'sd1,     1'b1, 16'sd0},
        '{4'd8,  16'd16384, MODE_CLIP,   16'sd300,    1'b0, 16'sd0},
        '{4'd15, 16'd16384, MODE_CLIP,   16'sd1,      1'b1, 16'sd2},
        '{4'd15, 16'd16384, MODE_CLIP,   -16'sd1,     1'b1, 16'sd0},
        '{4'd15, 16'd16384, MODE_CLIP,   16'sd12345,  1'b0, 16'sd0},
        '{4'd2,  16'd16384, MODE_CLIP,   16'sd1,      1'b1, 16'sd16384},
        '{4'd0,  16'd16384, MODE_CLIP,   16'sd1,      1'b1, 16'sd16384},
        '{4'd1,  16'd16384, MODE_CLIP,   -16'sd8193,  1'b0, 16'sd0},
        '{4'd8,  16'd0,     MODE_CLIP,   -16'sd32768, 1'b1, 16'sd0},
        '{4'd8,  16'd32768, MODE_CLIP,   16'sd32767,  1'b1, 16'sd32767},
        '{4'd8,  16'd32768, MODE_CLIP,   16'sd16384,  1'b1, 16'sd32767},
        '{4'd8,  16'd32768, MODE_WRAP,   16'sd16384,  1'b1, 16'sd32767},
        '{4'd15, 16'd32768, MODE_WRAP,   16'sd32767,  1'b0, 16'sd0},
        '{4'd15, 16'd32768, MODE_WRAP,   -16'sd32768, 1'b1, -16'sd32768},
        '{4'd15, 16'd32768, MODE_WRAP,   -16'sd20000, 1'b0, 16'sd0},
        '{4'd15, 16'd32768, MODE_FOLD,   -16'sd32768, 1'b1, 16'sd0},
        '{4'd15, 16'd32768, MODE_FOLD,   16'sd32767,  1'b0, 16'sd0},
        '{4'd15, 16'd32768, MODE_FOLD,   16'sd16384,  1'b1, 16'sd32767},
        '{4'd15, 16'd65535, MODE_FOLD,   -16'sd32768, 1'b0, 16'sd0},
        '{4'd8,  16'd65535, MODE_UNUSED, -16'sd32768, 1'b1, -16'sd32768},
        '{4'd15, 16'd65535, MODE_WRAP,   16'sd32767,  1'b0, 16'sd0}
    };

    gain_fold_bitcrusher #(.SAMPLE_BITS(SAMPLE_BITS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .start     (start),
        .busy      (busy),
        .audio_in  (audio_in),
        .done      (done),
        .audio_out (audio_out)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [SAMPLE_BITS-1:0] crush_sample(
        input logic signed [SAMPLE_BITS-1:0] smp,
        input cfg_t                          c
    );
        longint one;
        longint prod;
        longint lim;
        longint bias;
        longint grid_k;
        longint q;
        int     n;
        int     s;
        one  = longint'(1) << PROD_FRAC;
        prod = longint'(smp) * longint'({1'b0, c.gain});
        case (c.fold_mode)
            MODE_WRAP:
                lim = (prod > one) ? prod - one : (prod < -one) ? prod + one : prod;
            MODE_FOLD:
                lim = (prod > one) ? 2 * one - prod : (prod < -one) ? -2 * one - prod : prod;
            default:
                lim = (prod > one) ? one : (prod < -one) ? -one : prod;
        endcase
        n = int'(c.bit_depth);
        if (n < 2)
            n = 2;
        if (n > SAMPLE_BITS)
            n = SAMPLE_BITS;
        s      = PROD_FRAC + 1 - n;
        bias   = longint'(1) << (PROD_FRAC + 3);
        grid_k = (lim + bias + (longint'(1) << s) - 1) >>> s;
        q      = (grid_k <<< (s - GAIN_FRAC)) - (bias >>> GAIN_FRAC);
        if (q > (longint'(1) << (SAMPLE_BITS - 1)) - 1)
            q = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        if (q < -(longint'(1) << (SAMPLE_BITS - 1)))
            q = -(longint'(1) << (SAMPLE_BITS - 1));
        return q[SAMPLE_BITS-1:0];
    endfunction

    task automatic apb_write(input logic [REG_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_requests();
        @(negedge clk);
        start <= 1'b0;
        while (crushed_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_config(input cfg_t c);
        drain_requests();
        apb_write(REG_BIT_DEPTH, DATA_W'(c.bit_depth));
        apb_write(REG_GAIN, DATA_W'(c.gain));
        apb_write(REG_FOLD_MODE, DATA_W'(c.fold_mode));
        cfg = c;
    endtask

    task automatic send_sample(
        input logic signed [SAMPLE_BITS-1:0] smp,
        input logic signed [SAMPLE_BITS-1:0] expected,
        input int                            gap
    );
        @(negedge clk);
        start    <= 1'b1;
        audio_in <= smp;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        crushed_due.insert(crushed_due.size(), expected);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0:
                case ($urandom_range(0, 6))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    4: return 16'sd1;
                    5: return 16'sd16384;
                    default: return -16'sd16384;
                endcase
            1: return SAMPLE_BITS'($urandom_range(0, 512) - 256);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic cfg_t draw_config();
        cfg_t c;
        if ($urandom_range(0, 3) == 0)
            case ($urandom_range(0, 3))
                0: c.bit_depth = 4'd0;
                1: c.bit_depth = 4'd1;
                2: c.bit_depth = 4'd2;
                default: c.bit_depth = 4'd15;
            endcase
        else
            c.bit_depth = DEPTH_W'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
            0: c.gain = 16'd0;
            1: c.gain = 16'd16384;
            2: c.gain = 16'd32768;
            3: c.gain = 16'd65535;
            default: c.gain = GAIN_W'($urandom);
        endcase
        c.fold_mode = MODE_W'($urandom_range(0, 3));
        return c;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (crushed_due.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected result audio_out=%0d", audio_out);
            end
            else
            begin
                due_head = crushed_due.pop_front();
                if (audio_out !== due_head)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("audio_out mismatch: expected %0d, got %0d",
                                 due_head, audio_out);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_t row_cfg;
        cfg_t phase_cfg;
        logic signed [SAMPLE_BITS-1:0] smp;
        bit burst;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        start    = 1'b0;
        audio_in = '0;
        cfg.bit_depth = BIT_DEPTH_RST;
        cfg.gain      = GAIN_RST;
        cfg.fold_mode = FOLD_MODE_RST;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row_cfg.bit_depth = directed_rows[i].depth;
            row_cfg.gain      = directed_rows[i].gn;
            row_cfg.fold_mode = directed_rows[i].mode;
            if (row_cfg != cfg)
                load_config(row_cfg);
            send_sample(directed_rows[i].smp,
                        directed_rows[i].known ? directed_rows[i].result
                                               : crush_sample(directed_rows[i].smp, cfg),
                        $urandom_range(0, MAX_GAP));
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            phase_cfg = draw_config();
            load_config(phase_cfg);
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                smp = draw_sample();
                send_sample(smp, crush_sample(smp, cfg),
                            burst ? 0 : $urandom_range(0, MAX_GAP));
            end
        end

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && crushed_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/gfb_pkg.sv
hw/rtl/gfb_regs.sv
hw/rtl/gfb_limit.sv
hw/rtl/gfb_quant.sv
hw/rtl/gain_fold_bitcrusher.sv
hw/rtl/gfb_checker.sv
bench/gain_fold_bitcrusher_tb.sv
